// ===== sv/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
`default_nettype none

package u8u16_pkg;

  localparam int BYTE_W    = 8;
  localparam int UNIT_W    = 16;
  localparam int PEND_W    = 2;
  localparam int PARTIAL_W = 10;

  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_MASK   = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_CODE   = 8'h80;

  // Continuation bytes still expected
  localparam logic [PEND_W-1:0] PEND_IDLE = 2'd0;
  localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
  localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

  typedef struct packed {
    logic [PEND_W-1:0]    pending;
    logic [PARTIAL_W-1:0] partial;
  } dec_state_t;

  typedef struct packed {
    logic              emit;
    logic [UNIT_W-1:0] code_unit;
    logic              is_error;
    logic              end_of_string;
  } dec_result_t;

endpackage

`default_nettype wire

// ===== sv/u8u16_if.sv =====
// Valid/ready channel interfaces for the decoder's byte input and code unit output.
`default_nettype none

interface u8u16_in_if
  import u8u16_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if
  import u8u16_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              is_error;
  logic              end_of_string;

  modport source (output valid, output code_unit, output is_error, output end_of_string,
                  input ready);
  modport sink   (input valid, input code_unit, input is_error, input end_of_string,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/u8u16_step.sv =====
// One-byte decode step: next sequence state and optional result from current state.
`default_nettype none

module u8u16_step
  import u8u16_pkg::*;
(
  input  dec_state_t        cur,
  input  logic [BYTE_W-1:0] in_byte,
  output dec_state_t        nxt,
  output dec_result_t       res
);

  logic [UNIT_W-1:0] acc;

  assign acc = {cur.partial, in_byte[5:0]};

  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.pending == PEND_IDLE) begin
      if (in_byte < ASCII_LIMIT) begin
        res.emit          = 1'b1;
        res.code_unit     = {{(UNIT_W-BYTE_W){1'b0}}, in_byte};
        res.end_of_string = (in_byte == '0);
      end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
        nxt.partial = {{(PARTIAL_W-5){1'b0}}, in_byte[4:0]};
        nxt.pending = PEND_ONE;
      end else begin
        // all other non-ASCII bytes (three- and four-byte leads, stray continuations) open a three-byte sequence
        nxt.partial = {{(PARTIAL_W-4){1'b0}}, in_byte[3:0]};
        nxt.pending = PEND_TWO;
      end
    end else if ((in_byte & CONT_MASK) != CONT_CODE) begin
      nxt          = '0;
      res.emit     = 1'b1;
      res.is_error = 1'b1;
    end else if (cur.pending == PEND_ONE) begin
      nxt           = '0;
      res.emit      = 1'b1;
      res.code_unit = acc;
    end else begin
      nxt.partial = acc[PARTIAL_W-1:0];
      nxt.pending = PEND_ONE;
    end
  end

endmodule

`default_nettype wire

// ===== sv/utf8_to_utf16_decoder_core.sv =====
// UTF-8 byte stream to 16-bit code unit decoder, top level.
//
// byte_in carries one raw UTF-8 byte per transaction; unit_out carries one
// decoded 16-bit code unit with is_error and end_of_string flags.
// ASCII bytes and the zero terminator give one result each; a lead byte and
// every non-final continuation give none; the final continuation gives the
// completed code unit; a malformed continuation gives an error result
// (code unit 0) and drops back to idle, consuming the offending byte.
// Throughput: one byte per cycle while unit_out is not stalled. The decode is a
// single combinational step on the sequence state, and its result is loaded
// into the output register on the clock edge that accepts the byte.
// The output register frees itself in the same cycle it is read, so byte_in
// stays ready while unit_out is taken every cycle. When the receiver stalls
// with a result held, byte_in drops ready until that result is taken.
// Reset (rst, synchronous) empties the output register and returns the
// sequence state to idle with no gathered bits.
`default_nettype none

module utf8_to_utf16_decoder_core
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  u8u16_in_if.sink    byte_in,
  u8u16_out_if.source unit_out
);

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_res;
  logic        in_fire;
  logic        out_valid;
  logic [UNIT_W-1:0] code_unit;
  logic        is_error;
  logic        end_of_string;

  u8u16_step u_step (
    .cur     (state),
    .in_byte (byte_in.in_byte),
    .nxt     (state_next),
    .res     (step_res)
  );

  assign byte_in.ready = !out_valid || unit_out.ready;
  assign in_fire       = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      if (in_fire && step_res.emit) begin
        out_valid <= 1'b1;
      end else if (unit_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: load with each emitted result
  always_ff @(posedge clk) begin
    if (in_fire && step_res.emit) begin
      code_unit     <= step_res.code_unit;
      is_error      <= step_res.is_error;
      end_of_string <= step_res.end_of_string;
    end
  end

  assign unit_out.valid         = out_valid;
  assign unit_out.code_unit     = code_unit;
  assign unit_out.is_error      = is_error;
  assign unit_out.end_of_string = end_of_string;

  a_pending_range: assert property (@(posedge clk) disable iff (rst)
    state.pending != 2'd3)
    else $error("pending count reached an unused code");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    in_fire && step_res.emit |=> out_valid)
    else $error("emitted result not held in output register");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_error |-> code_unit == '0 && !end_of_string)
    else $error("error result carries a code unit or terminator flag");

  a_eos_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> code_unit == '0)
    else $error("terminator result carries a nonzero code unit");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && step_res.emit |=> state.pending == PEND_IDLE && state.partial == '0)
    else $error("sequence state not idle after a result");

endmodule

`default_nettype wire
